@@ rtl/rc4_pkg.sv @@
// Shared types and constants for the RC4 keystream cipher core.
package rc4_pkg;

  localparam int PermDepth   = 256;
  localparam int AddrW       = 8;
  localparam int ByteW       = 8;
  localparam int MaxKeyBytes = 16;
  localparam int RegKeyBytes = 16;
  localparam int KeyCap      = (MaxKeyBytes < RegKeyBytes) ? MaxKeyBytes : RegKeyBytes;
  localparam int KeyLenW     = 5;
  localparam int KeyIdxW     = 4;
  localparam int KeyW        = RegKeyBytes * ByteW;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyLength   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLowWord  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyHighWord = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StFill,
    StKsRdN,
    StKsRdJ,
    StKsWrN,
    StKsWrJ,
    StPrgIssue,
    StPrgRdJ,
    StPrgWrI,
    StPrgWrJ,
    StOut
  } rc4_state_e;

  // One access slot of the permutation RAM
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Key material as seen by the sequencer
  typedef struct packed {
    logic [KeyLenW-1:0] len;
    logic [KeyW-1:0]    key;
  } key_cfg_t;

endpackage

@@ rtl/rc4_perm_ram.sv @@
// 256 x 8 permutation RAM, one write port and one registered read port.
module rc4_perm_ram (
  input  logic                     clk_i,
  input  rc4_pkg::mem_req_t        mem_req_i,
  output logic [rc4_pkg::ByteW-1:0] rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0] mem_q [PermDepth];
  logic [ByteW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rc4_seq.sv @@
// Sequencer: key schedule, keystream generation and output register.
module rc4_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rc4_pkg::ByteW-1:0] in_byte_i,
  input  logic                      start_of_message_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rc4_pkg::ByteW-1:0] out_byte_o,
  input  rc4_pkg::key_cfg_t         key_cfg_i,
  output rc4_pkg::mem_req_t         mem_req_o,
  input  logic [rc4_pkg::ByteW-1:0] mem_rdata_i
);
  import rc4_pkg::*;

  rc4_state_e         state_q, state_d;
  logic [AddrW-1:0]   i_q, i_d;
  logic [AddrW-1:0]   j_q, j_d;
  logic [AddrW-1:0]   n_q, n_d;
  logic [KeyIdxW-1:0] kidx_q, kidx_d;
  logic               sched_q, sched_d;
  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;
  logic [ByteW-1:0]   si_q, si_d;
  logic [ByteW-1:0]   sj_q, sj_d;
  logic [AddrW-1:0]   t_q, t_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic [ByteW-1:0]   ks_q, ks_d;

  logic               in_fire;
  logic               out_free;
  logic [ByteW-1:0]   key_byte;
  logic [KeyIdxW-1:0] kidx_next;
  logic [AddrW-1:0]   j_new;
  logic [ByteW-1:0]   ks_fwd;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Key byte n mod len, and the cyclic key index
  assign key_byte  = key_cfg_i.key[{kidx_q, 3'b000} +: ByteW];
  assign kidx_next = (({1'b0, kidx_q} + KeyLenW'(1)) == key_cfg_i.len) ? '0
                                                                       : kidx_q + KeyIdxW'(1);

  // Keystream read issued with the S[i] write: patch up the swapped entries
  always_comb begin
    priority if (t_q == j_q) begin
      ks_fwd = si_q;
    end else if (t_q == i_q) begin
      ks_fwd = sj_q;
    end else begin
      ks_fwd = mem_rdata_i;
    end
  end

  // Next state, datapath and RAM requests
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    sched_d     = sched_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    data_d      = data_q;
    ks_d        = ks_q;
    out_byte_d  = out_byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    j_new       = '0;
    mem_req_o   = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          data_d = in_byte_i;
          if (start_of_message_i || !sched_q) begin
            n_d     = '0;
            state_d = StFill;
          end else begin
            i_d             = i_q + AddrW'(1);
            mem_req_o.raddr = i_q + AddrW'(1);
            state_d         = StPrgRdJ;
          end
        end
      end

      // Identity permutation, one entry a cycle
      StFill: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = n_q;
        mem_req_o.wdata = n_q;
        n_d             = n_q + AddrW'(1);
        if (n_q == '1) begin
          j_d     = '0;
          kidx_d  = '0;
          state_d = StKsRdN;
        end
      end

      // Key schedule: read S[n]
      StKsRdN: begin
        mem_req_o.raddr = n_q;
        state_d         = StKsRdJ;
      end

      // Key schedule: j += S[n] + key, read S[j]
      StKsRdJ: begin
        si_d            = mem_rdata_i;
        j_new           = j_q + mem_rdata_i + key_byte;
        j_d             = j_new;
        mem_req_o.raddr = j_new;
        state_d         = StKsWrN;
      end

      // Key schedule: S[n] = S[j]
      StKsWrN: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = n_q;
        mem_req_o.wdata = mem_rdata_i;
        state_d         = StKsWrJ;
      end

      // Key schedule: S[j] = old S[n]
      StKsWrJ: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = si_q;
        n_d             = n_q + AddrW'(1);
        kidx_d          = kidx_next;
        if (n_q == '1) begin
          i_d     = '0;
          j_d     = '0;
          sched_d = 1'b1;
          state_d = StPrgIssue;
        end else begin
          state_d = StKsRdN;
        end
      end

      // Keystream: i += 1, read S[i]
      StPrgIssue: begin
        i_d             = i_q + AddrW'(1);
        mem_req_o.raddr = i_q + AddrW'(1);
        state_d         = StPrgRdJ;
      end

      // Keystream: j += S[i], read S[j]
      StPrgRdJ: begin
        si_d            = mem_rdata_i;
        j_new           = j_q + mem_rdata_i;
        j_d             = j_new;
        mem_req_o.raddr = j_new;
        state_d         = StPrgWrI;
      end

      // Keystream: S[i] = S[j], read S[S[i] + S[j]]
      StPrgWrI: begin
        sj_d            = mem_rdata_i;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = i_q;
        mem_req_o.wdata = mem_rdata_i;
        t_d             = si_q + mem_rdata_i;
        mem_req_o.raddr = si_q + mem_rdata_i;
        state_d         = StPrgWrJ;
      end

      // Keystream: S[j] = old S[i], keystream byte ready
      StPrgWrJ: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = si_q;
        ks_d            = ks_fwd;
        if (out_free) begin
          out_byte_d  = data_q ^ ks_fwd;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end else begin
          state_d = StOut;
        end
      end

      // Hold until the output register frees up
      StOut: begin
        if (out_free) begin
          out_byte_d  = data_q ^ ks_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      kidx_q      <= kidx_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    data_q     <= data_d;
    ks_q       <= ks_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

@@ rtl/rc4_keystream_cipher_core.sv @@
// RC4 keystream cipher core: one message byte per item, XORed with the keystream.
// One item at a time: a new byte is taken only in StIdle, once the last result is registered; the pace is set by
//   three dependent reads of the permutation RAM (S[i], S[j], S[S[i]+S[j]]) and the swap.
// Start-of-message items, and the first item after reset, first fill the identity over 256
//   entries, run the key schedule over 256 entries and issue the S[i] read in StPrgIssue.
// Reset (rst_ni, async, active low) clears indices, scheduled flag, handshakes and keys.
module rc4_keystream_cipher_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rc4_pkg::ByteW-1:0]    in_byte_i,
  input  logic                         start_of_message_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rc4_pkg::ByteW-1:0]    out_byte_o,
  input  logic                         cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rc4_pkg::CfgDataW-1:0] cfg_data_i
);
  import rc4_pkg::*;

  logic [KeyLenW-1:0]  key_length_q;
  logic [CfgDataW-1:0] key_low_q;
  logic [CfgDataW-1:0] key_high_q;
  logic [KeyLenW-1:0]  eff_len;
  key_cfg_t            key_cfg;
  mem_req_t            mem_req;
  logic [ByteW-1:0]    mem_rdata;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KeyLenW'(1);
      key_low_q    <= '0;
      key_high_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgKeyLength:   key_length_q <= cfg_data_i[KeyLenW-1:0];
        CfgKeyLowWord:  key_low_q    <= cfg_data_i;
        CfgKeyHighWord: key_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp key length to 1..KeyCap
  always_comb begin
    priority if (key_length_q == '0) begin
      eff_len = KeyLenW'(1);
    end else if (key_length_q > KeyLenW'(KeyCap)) begin
      eff_len = KeyLenW'(KeyCap);
    end else begin
      eff_len = key_length_q;
    end
  end

  assign key_cfg = {eff_len, key_high_q, key_low_q};

  rc4_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_byte_i          (in_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .key_cfg_i          (key_cfg),
    .mem_req_o          (mem_req),
    .mem_rdata_i        (mem_rdata)
  );

  rc4_perm_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // An accepted transaction keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while previous transaction still in progress");

  // No RAM writes while waiting for input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_req.we)
    else $error("permutation write while idle");

  // A new result only follows a cycle of work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

endmodule
